@@ hdl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define TMPM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tmpm assertion failed");

// next-cycle implication, off while reset is asserted
`define TMPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tmpm assertion failed");

`endif

@@ hdl/tmpm_pkg.sv @@
package tmpm_pkg;

  localparam int unsigned CH_W    = 16;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned MODE_W  = 3;

  localparam logic [CH_W-1:0] FULL16 = 16'hFFFF;

  // q16 luma weights, sum is exactly 65536
  localparam logic [CH_W-1:0] WEIGHT_R = 16'd19595;
  localparam logic [CH_W-1:0] WEIGHT_G = 16'd38470;
  localparam logic [CH_W-1:0] WEIGHT_B = 16'd7471;
  localparam logic [2:0][CH_W-1:0] LUMA_WEIGHT = {WEIGHT_B, WEIGHT_G, WEIGHT_R};

  // quotient bits resolved per divider stage
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = CH_W / DIV_STEPS;

  // pipeline stage numbers
  localparam int unsigned ST_IN       = 1;
  localparam int unsigned ST_DIV_LAST = ST_IN + DIV_STAGES;
  localparam int unsigned ST_WEIGHT   = ST_DIV_LAST + 1;
  localparam int unsigned ST_MASK     = ST_WEIGHT + 1;
  localparam int unsigned ST_PROD     = ST_MASK + 1;
  localparam int unsigned ST_OUT      = ST_PROD + 1;
  localparam int unsigned NUM_ST      = ST_OUT;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE      = 3'd0,
    MODE_ALPHA     = 3'd1,
    MODE_ALPHA_INV = 3'd2,
    MODE_LUMA      = 3'd3,
    MODE_LUMA_INV  = 3'd4
  } matte_mode_t;

  typedef enum logic {
    REG_MATTE_MODE = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] layer_red;
    logic [CH_W-1:0] layer_green;
    logic [CH_W-1:0] layer_blue;
    logic [CH_W-1:0] layer_alpha;
    logic [CH_W-1:0] matte_red;
    logic [CH_W-1:0] matte_green;
    logic [CH_W-1:0] matte_blue;
    logic [CH_W-1:0] matte_alpha;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } out_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pix_t;

  // divider stage: partial remainder and quotient per matte channel
  typedef struct packed {
    pix_t                  layer;
    logic [CH_W-1:0]       ma;
    logic [2:0][CH_W-1:0]  rem;
    logic [2:0][CH_W-1:0]  quo;
    logic [2:0]            sat;
  } dstage_t;

  typedef struct packed {
    pix_t                   layer;
    logic [CH_W-1:0]        ma;
    logic [2:0][2*CH_W-1:0] wprod;
  } wstage_t;

  typedef struct packed {
    pix_t            layer;
    logic [CH_W-1:0] mask;
  } mstage_t;

  typedef logic [3:0][2*CH_W-1:0] pstage_t;

  // floor(p / 65535) for p <= 65535*65535: one add, one compare
  function automatic logic [CH_W-1:0] div_full16(input logic [2*CH_W-1:0] p);
    logic [CH_W-1:0] hi;
    logic [CH_W:0]   s;
    hi = p[2*CH_W-1:CH_W];
    s  = {1'b0, p[CH_W-1:0]} + {1'b0, hi};
    return hi + CH_W'(s >= {1'b0, FULL16});
  endfunction

endpackage

@@ hdl/track_matte_pixel_mask_core.sv @@
// throughput: one pixel per clock while the output is not stalled; every stage is registered and fully pipelined
// the matte divide (channel*65535/alpha) runs 2 quotient bits per stage over 8 stages
// reset (rst_n low, synchronous) empties the pipeline and sets matte_mode to none
module track_matte_pixel_mask_core import tmpm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // pixel input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  // masked pixel output channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // stage map
  //   1      : form numerators c*65535 and saturation flags
  //   2..9   : restoring divide, three channels in parallel
  //   10     : pick straight channel, multiply by luma weight
  //   11     : sum weights, clamp, select mask by mode
  //   12     : multiply each layer channel by mask
  //   13     : divide by 65535 (output register)

  logic [MODE_W-1:0] matte_mode;

  tmpm_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .matte_mode (matte_mode)
  );

  // ---------------------------------------------------------------
  // flow control: a stage loads when it is empty or its content moves on,
  // so bubbles close up even while the output is stalled
  // ---------------------------------------------------------------
  logic [NUM_ST:1]   v_r;
  logic [NUM_ST:1]   v_nxt;
  logic [NUM_ST:0]   v_up;
  logic [NUM_ST+1:1] ld;

  assign v_up          = {v_r, in_valid};
  assign ld[NUM_ST+1]  = !out_stall;

  genvar gi;
  generate
    for (gi = 1; gi <= NUM_ST; gi++) begin : g_flow
      assign ld[gi]    = !v_r[gi] || ld[gi+1];
      assign v_nxt[gi] = ld[gi] ? v_up[gi-1] : v_r[gi];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !ld[ST_IN];
  assign out_valid = v_r[ST_OUT];

  // ---------------------------------------------------------------
  // stage 1: numerator = c*65535 = (c << 16) - c
  // when c >= alpha and alpha is nonzero the straight value clamps to full scale
  // ---------------------------------------------------------------
  dstage_t              dp_r   [ST_IN:ST_DIV_LAST];
  dstage_t              dp_nxt [ST_IN:ST_DIV_LAST];
  logic [2:0][CH_W-1:0] mc;
  logic [2:0][2*CH_W-1:0] num;

  assign mc[0] = in_data.matte_red;
  assign mc[1] = in_data.matte_green;
  assign mc[2] = in_data.matte_blue;

  always_comb begin
    dp_nxt[ST_IN].layer.red   = in_data.layer_red;
    dp_nxt[ST_IN].layer.green = in_data.layer_green;
    dp_nxt[ST_IN].layer.blue  = in_data.layer_blue;
    dp_nxt[ST_IN].layer.alpha = in_data.layer_alpha;
    dp_nxt[ST_IN].ma          = in_data.matte_alpha;
    for (int c = 0; c < 3; c++) begin
      num[c]                = {mc[c], {CH_W{1'b0}}} - {{CH_W{1'b0}}, mc[c]};
      dp_nxt[ST_IN].rem[c]  = num[c][2*CH_W-1:CH_W];
      dp_nxt[ST_IN].quo[c]  = num[c][CH_W-1:0];
      dp_nxt[ST_IN].sat[c]  = (mc[c] >= in_data.matte_alpha);
    end
  end

  // ---------------------------------------------------------------
  // stages 2..9: divide numerator by matte alpha, DIV_STEPS bits a stage
  // ---------------------------------------------------------------
  genvar gs, gc;
  generate
    for (gs = ST_IN + 1; gs <= ST_DIV_LAST; gs++) begin : g_div
      assign dp_nxt[gs].layer = dp_r[gs-1].layer;
      assign dp_nxt[gs].ma    = dp_r[gs-1].ma;
      assign dp_nxt[gs].sat   = dp_r[gs-1].sat;
      for (gc = 0; gc < 3; gc++) begin : g_ch
        tmpm_div_step #(
          .STEPS (DIV_STEPS)
        ) u_step (
          .rem_i (dp_r[gs-1].rem[gc]),
          .quo_i (dp_r[gs-1].quo[gc]),
          .den_i (dp_r[gs-1].ma),
          .rem_o (dp_nxt[gs].rem[gc]),
          .quo_o (dp_nxt[gs].quo[gc])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int s = ST_IN; s <= ST_DIV_LAST; s++) begin
      if (ld[s]) begin
        dp_r[s] <= dp_nxt[s];
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 10: straight channel (zero alpha gives 0, clamp to full scale)
  // times its q16 luma weight
  // ---------------------------------------------------------------
  wstage_t              ws_r;
  wstage_t              ws_nxt;
  logic [2:0][CH_W-1:0] straight;

  always_comb begin
    ws_nxt.layer = dp_r[ST_DIV_LAST].layer;
    ws_nxt.ma    = dp_r[ST_DIV_LAST].ma;
    for (int c = 0; c < 3; c++) begin
      if (dp_r[ST_DIV_LAST].ma == '0) begin
        straight[c] = '0;
      end else if (dp_r[ST_DIV_LAST].sat[c]) begin
        straight[c] = FULL16;
      end else begin
        straight[c] = dp_r[ST_DIV_LAST].quo[c];
      end
      ws_nxt.wprod[c] = (2*CH_W)'(straight[c]) * (2*CH_W)'(LUMA_WEIGHT[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_WEIGHT]) begin
      ws_r <= ws_nxt;
    end
  end

  // ---------------------------------------------------------------
  // stage 11: luma sum and mask select
  // ---------------------------------------------------------------
  mstage_t         ms_r;
  mstage_t         ms_nxt;
  logic [CH_W-1:0] mask_w;

  tmpm_mask u_mask (
    .mode  (matte_mode),
    .ma    (ws_r.ma),
    .wprod (ws_r.wprod),
    .mask  (mask_w)
  );

  assign ms_nxt.layer = ws_r.layer;
  assign ms_nxt.mask  = mask_w;

  always_ff @(posedge clk) begin
    if (ld[ST_MASK]) begin
      ms_r <= ms_nxt;
    end
  end

  // ---------------------------------------------------------------
  // stage 12: channel * mask, four multipliers
  // ---------------------------------------------------------------
  pstage_t pp_r;
  pstage_t pp_nxt;

  assign pp_nxt[0] = (2*CH_W)'(ms_r.layer.red)   * (2*CH_W)'(ms_r.mask);
  assign pp_nxt[1] = (2*CH_W)'(ms_r.layer.green) * (2*CH_W)'(ms_r.mask);
  assign pp_nxt[2] = (2*CH_W)'(ms_r.layer.blue)  * (2*CH_W)'(ms_r.mask);
  assign pp_nxt[3] = (2*CH_W)'(ms_r.layer.alpha) * (2*CH_W)'(ms_r.mask);

  always_ff @(posedge clk) begin
    if (ld[ST_PROD]) begin
      pp_r <= pp_nxt;
    end
  end

  // ---------------------------------------------------------------
  // stage 13: floor(product / 65535) into the output register
  // ---------------------------------------------------------------
  out_t out_r;
  out_t out_nxt;

  assign out_nxt.out_red   = div_full16(pp_r[0]);
  assign out_nxt.out_green = div_full16(pp_r[1]);
  assign out_nxt.out_blue  = div_full16(pp_r[2]);
  assign out_nxt.out_alpha = div_full16(pp_r[3]);

  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

@@ hdl/tmpm_cfg.sv @@
module tmpm_cfg import tmpm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [MODE_W-1:0]  matte_mode
);

  logic [MODE_W-1:0] mode_r;
  logic [MODE_W-1:0] mode_nxt;
  logic              wr_en;
  logic              hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1] == REG_MATTE_MODE);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    mode_nxt = mode_r;
    if (wr_en && hit) begin
      mode_nxt = pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign prdata     = hit ? PDATA_W'(mode_r) : '0;
  assign matte_mode = mode_r;

endmodule

@@ hdl/tmpm_div_step.sv @@
module tmpm_div_step import tmpm_pkg::*; #(
  parameter int unsigned STEPS = 2
) (
  input  logic [CH_W-1:0] rem_i,
  input  logic [CH_W-1:0] quo_i,
  input  logic [CH_W-1:0] den_i,
  output logic [CH_W-1:0] rem_o,
  output logic [CH_W-1:0] quo_o
);

  logic [CH_W-1:0] r;
  logic [CH_W-1:0] q;
  logic [CH_W:0]   t;

  // restoring division: numerator low bits shift out of q as quotient bits shift in
  always_comb begin
    r = rem_i;
    q = quo_i;
    t = '0;
    for (int k = 0; k < STEPS; k++) begin
      t = {r, q[CH_W-1]};
      if (t >= {1'b0, den_i}) begin
        r = CH_W'(t - {1'b0, den_i});
        q = {q[CH_W-2:0], 1'b1};
      end else begin
        r = t[CH_W-1:0];
        q = {q[CH_W-2:0], 1'b0};
      end
    end
  end

  assign rem_o = r;
  assign quo_o = q;

endmodule

@@ hdl/tmpm_mask.sv @@
module tmpm_mask import tmpm_pkg::*; (
  input  logic [MODE_W-1:0]      mode,
  input  logic [CH_W-1:0]        ma,
  input  logic [2:0][2*CH_W-1:0] wprod,
  output logic [CH_W-1:0]        mask
);

  logic [2*CH_W+1:0] sum;
  logic [CH_W+1:0]   y_raw;
  logic [CH_W-1:0]   luma;

  assign sum   = (2*CH_W+2)'(wprod[0]) + (2*CH_W+2)'(wprod[1]) + (2*CH_W+2)'(wprod[2]);
  assign y_raw = sum[2*CH_W+1:CH_W];
  assign luma  = (y_raw > (CH_W+2)'(FULL16)) ? FULL16 : y_raw[CH_W-1:0];

  always_comb begin
    case (mode)
      MODE_ALPHA:     mask = ma;
      MODE_ALPHA_INV: mask = FULL16 - ma;
      MODE_LUMA:      mask = luma;
      MODE_LUMA_INV:  mask = FULL16 - luma;
      default:        mask = FULL16;
    endcase
  end

endmodule

@@ hdl/tmpm_checker.sv @@
`include "assert_macros.svh"

module tmpm_checker import tmpm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input out_t               out_data,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata
);

  logic               mode_wr;
  logic [PDATA_W-1:0] mode_wdata;

  assign mode_wr    = psel && penable && pwrite && !paddr[PADDR_W-1];
  assign mode_wdata = PDATA_W'(pwdata[MODE_W-1:0]);

  // input only backs up when the whole pipe is full and the output is held
  `TMPM_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && out_stall)

  // a held result keeps its payload
  `TMPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // the pipe comes out of reset empty
  `TMPM_ASSERT_NOW(a_reset_empty, clk, rst_n, !$past(rst_n), !out_valid)

  // a mode write reads back as its low three bits
  `TMPM_ASSERT_NEXT(a_mode_readback, clk, rst_n, mode_wr, paddr[PADDR_W-1] || (prdata == $past(mode_wdata)))

endmodule

bind track_matte_pixel_mask_core tmpm_checker u_tmpm_checker (.*);
